// ===== hdl/adtshp_pkg.sv =====
// shared types, constants and the sample-rate table for the adts header parser
package adtshp_pkg;

   localparam int HEADER_BYTES = 7;
   localparam int INDEX_W      = $clog2(HEADER_BYTES + 1);
   localparam int OFFSET_W     = 32;
   localparam int RATE_W       = 17;
   localparam int TDATA_W      = 88;

   typedef logic [INDEX_W-1:0] index_type;

   localparam index_type INDEX_SEARCH = index_type'(0);
   localparam index_type INDEX_SYNCED = index_type'(2);
   localparam index_type INDEX_CHECK  = index_type'(3);
   localparam index_type INDEX_LAST   = index_type'(HEADER_BYTES);

   localparam logic [7:0] SYNC_BYTE   = 8'hFF;
   localparam logic [3:0] SYNC_NIBBLE = 4'hF;
   localparam logic [1:0] LAYER_AAC   = 2'd0;
   localparam logic [1:0] PROFILE_BAD = 2'd3;

   typedef struct packed {
      logic [1:0]          raw_block_count;
      logic [10:0]         buffer_fullness;
      logic [12:0]         frame_length;
      logic                copyright_id_start;
      logic                copyright_id_bit;
      logic [2:0]          channel_config;
      logic [RATE_W-1:0]   sample_rate_hz;
      logic [1:0]          profile_code;
      logic                crc_absent;
      logic [OFFSET_W-1:0] header_offset;
   } result_type;

   function automatic logic [RATE_W-1:0] rate_hz(input logic [3:0] rate_index);
      logic [RATE_W-1:0] hz;
      case (rate_index)
         4'd0:    hz = 17'd96000;
         4'd1:    hz = 17'd88200;
         4'd2:    hz = 17'd64000;
         4'd3:    hz = 17'd48000;
         4'd4:    hz = 17'd44100;
         4'd5:    hz = 17'd32000;
         4'd6:    hz = 17'd24000;
         4'd7:    hz = 17'd22050;
         4'd8:    hz = 17'd16000;
         4'd9:    hz = 17'd12000;
         4'd10:   hz = 17'd11025;
         4'd11:   hz = 17'd8000;
         default: hz = '0;
      endcase
      return hz;
   endfunction

endpackage

// ===== hdl/adts_header_sync_parser_core.sv =====
// top level of the adts header sync parser
// Takes one stream byte per cycle and reports each valid ADTS header as one
// transaction holding the decoded fields and the byte offset of its first sync
// byte. Bytes pass through an input register into the parser and the result
// lands in an output register, which offers a header's transaction once its
// last byte has passed both registers; the sustained rate is one byte per
// cycle, limited only by the result side holding its output register.
module adts_header_sync_parser_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // data_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // header_offset, crc_absent, profile_code, sample_rate_hz,
   // channel_config, copyright_id_bit, copyright_id_start, frame_length,
   // buffer_fullness, raw_block_count, zero pad
   output logic [adtshp_pkg::TDATA_W-1:0]     rsp_tdata
);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   out_valid_ff, out_valid_in;
   adtshp_pkg::result_type out_data_ff;
   logic                   advance;
   logic                   result_valid;
   adtshp_pkg::result_type result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && result_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   adtshp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .data_byte    (in_byte_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && result_valid) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(adtshp_pkg::TDATA_W - $bits(adtshp_pkg::result_type)){1'b0}},
                        out_data_ff};

endmodule

// ===== hdl/adtshp_parser.sv =====
// sync search and header gathering state, one byte per step
module adtshp_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              data_byte,
   output logic                    result_valid,
   output adtshp_pkg::result_type  result
);

   logic [7:0]                      prev_byte_ff, prev_byte_in;
   logic                            prev_valid_ff, prev_valid_in;
   adtshp_pkg::index_type           index_ff, index_in;
   logic [39:0]                     hdr_ff, hdr_in;
   logic [adtshp_pkg::OFFSET_W-1:0] pos_ff, pos_in;
   logic [adtshp_pkg::OFFSET_W-1:0] start_ff, start_in;
   adtshp_pkg::index_type           index_next;
   logic [47:0]                     full;
   logic                            sync_hit;
   logic                            bad_check;

   assign full       = {hdr_ff, data_byte};
   assign index_next = index_ff + adtshp_pkg::index_type'(1);
   assign sync_hit   = prev_valid_ff && (prev_byte_ff == adtshp_pkg::SYNC_BYTE)
                       && (data_byte[7:4] == adtshp_pkg::SYNC_NIBBLE);
   assign bad_check  = (data_byte[7:6] == adtshp_pkg::PROFILE_BAD)
                       || (adtshp_pkg::rate_hz(data_byte[5:2]) == '0);

   always_comb begin
      prev_byte_in  = prev_byte_ff;
      prev_valid_in = prev_valid_ff;
      index_in      = index_ff;
      hdr_in        = hdr_ff;
      pos_in        = pos_ff;
      start_in      = start_ff;
      result_valid  = 1'b0;
      if (step) begin
         pos_in = pos_ff + 32'd1;
         if (index_ff == adtshp_pkg::INDEX_SEARCH) begin
            if (sync_hit) begin
               if (data_byte[2:1] != adtshp_pkg::LAYER_AAC) begin
                  prev_valid_in = 1'b0;
                  prev_byte_in  = '0;
               end else begin
                  start_in = pos_ff - 32'd1;
                  hdr_in   = {hdr_ff[31:0], data_byte};
                  index_in = adtshp_pkg::INDEX_SYNCED;
               end
            end else begin
               prev_byte_in  = data_byte;
               prev_valid_in = 1'b1;
            end
         end else begin
            hdr_in = {hdr_ff[31:0], data_byte};
            if ((index_next == adtshp_pkg::INDEX_CHECK) && bad_check) begin
               index_in      = adtshp_pkg::INDEX_SEARCH;
               prev_valid_in = 1'b0;
               prev_byte_in  = '0;
            end else if (index_next == adtshp_pkg::INDEX_LAST) begin
               result_valid  = 1'b1;
               index_in      = adtshp_pkg::INDEX_SEARCH;
               prev_valid_in = 1'b0;
               prev_byte_in  = '0;
            end else begin
               index_in = index_next;
            end
         end
      end
   end

   always_comb begin
      result.header_offset      = start_ff;
      result.crc_absent         = full[40];
      result.profile_code       = full[39:38];
      result.sample_rate_hz     = adtshp_pkg::rate_hz(full[37:34]);
      result.channel_config     = full[32:30];
      result.copyright_id_bit   = full[27];
      result.copyright_id_start = full[26];
      result.frame_length       = full[25:13];
      result.buffer_fullness    = full[12:2];
      result.raw_block_count    = full[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_byte_ff  <= '0;
         prev_valid_ff <= 1'b0;
         index_ff      <= adtshp_pkg::INDEX_SEARCH;
         pos_ff        <= '0;
         start_ff      <= '0;
      end else begin
         prev_byte_ff  <= prev_byte_in;
         prev_valid_ff <= prev_valid_in;
         index_ff      <= index_in;
         pos_ff        <= pos_in;
         start_ff      <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

endmodule

// ===== hdl/adtshp_checker.sv =====
// port-level checks for the adts header sync parser, bound to the top level
module adtshp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown after reset");

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("headers reported too close together");

   a_fields_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[34:33] != 2'd3) && (rsp_tdata[51:35] != 17'd0)
                     && (rsp_tdata[87:83] == 5'd0))
      else $error("rejected header reported");

endmodule

bind adts_header_sync_parser_core adtshp_checker u_adtshp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
